// ===== design/cps_pkg.sv =====
// Shared constants, register codes and the pipeline context type for the pair separator.
`timescale 1ns / 1ps

package cps_pkg;

    // Species count; types beyond the last are folded onto the last one
    localparam int NUM_TYPES = 2;

    // Configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_MIN_SAME_A = 2'd0;
    localparam logic [1:0] REG_MIN_MIXED  = 2'd1;
    localparam logic [1:0] REG_MIN_SAME_B = 2'd2;
    localparam logic [1:0] REG_EXPAND     = 2'd3;

    // Iterative units: one result bit per stage
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 31;

    // Per-pair context that rides along with the arithmetic
    typedef struct packed {
        logic [2:0][31:0] pi;       // first atom, lane 0 = x
        logic [2:0][31:0] pj;       // second atom
        logic [2:0][31:0] mag;      // |pi - pj| per axis
        logic [2:0]       neg;      // pi - pj < 0 per axis
        logic             is_local; // second atom may move
        logic [32:0]      tgt;      // target separation, Q16.16
        logic             near;     // 0 < rsq <= dsq
        logic             coinc;    // rsq == 0
    } t_ctx;

endpackage

// ===== design/cps_sqrt.sv =====
// Pipelined integer square root of a 64-bit value, one root bit per stage.
`timescale 1ns / 1ps

module cps_sqrt import cps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [63:0] i_rad,
    input  t_ctx        i_ctx,
    output logic        o_valid,
    output logic [31:0] o_root,
    output t_ctx        o_ctx
);

    logic [SQRT_STAGES-1:0] r_vld;
    logic [63:0]            r_rad  [SQRT_STAGES];
    logic [33:0]            r_rem  [SQRT_STAGES];
    logic [31:0]            r_root [SQRT_STAGES];
    t_ctx                   r_ctx  [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_step
        logic        w_vld;
        logic [63:0] w_rad;
        logic [33:0] w_rem;
        logic [31:0] w_root;
        t_ctx        w_ctx;
        logic [35:0] w_acc;
        logic [35:0] w_trial;
        logic        w_take;

        if (k == 0) begin : g_first
            assign w_vld  = i_valid;
            assign w_rad  = i_rad;
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_ctx  = i_ctx;
        end else begin : g_next
            assign w_vld  = r_vld[k-1];
            assign w_rad  = r_rad[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_ctx  = r_ctx[k-1];
        end

        // bring down the next bit pair, try root*4+1
        assign w_acc   = {w_rem, w_rad[63:62]};
        assign w_trial = {2'b00, w_root, 2'b01};
        assign w_take  = (w_acc >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= {w_rad[61:0], 2'b00};
                r_rem[k]  <= w_take ? 34'(w_acc - w_trial) : w_acc[33:0];
                r_root[k] <= {w_root[30:0], w_take};
                r_ctx[k]  <= w_ctx;
            end
        end
    end

    assign o_valid = r_vld[SQRT_STAGES-1];
    assign o_root  = r_root[SQRT_STAGES-1];
    assign o_ctx   = r_ctx[SQRT_STAGES-1];

endmodule

// ===== design/cps_div.sv =====
// Pipelined three-lane restoring divider, 63-bit dividends by a shared 32-bit divisor.
`timescale 1ns / 1ps

module cps_div import cps_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [2:0][62:0] i_num,
    input  logic [31:0]      i_den,
    input  t_ctx             i_ctx,
    output logic             o_valid,
    output logic [2:0][30:0] o_quot,
    output t_ctx             o_ctx
);

    logic [DIV_STAGES-1:0] r_vld;
    logic [2:0][31:0]      r_rem  [DIV_STAGES];
    logic [2:0][30:0]      r_low  [DIV_STAGES];
    logic [2:0][30:0]      r_quot [DIV_STAGES];
    logic [31:0]           r_den  [DIV_STAGES];
    t_ctx                  r_ctx  [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
        logic             w_vld;
        logic [2:0][31:0] w_rem;
        logic [2:0][30:0] w_low;
        logic [2:0][30:0] w_quot;
        logic [31:0]      w_den;
        t_ctx             w_ctx;
        logic [2:0][31:0] w_rem_n;
        logic [2:0]       w_take;

        if (k == 0) begin : g_first
            // quotient fits 31 bits, so the top half is already below the divisor
            assign w_vld  = i_valid;
            assign w_rem  = {i_num[2][62:31], i_num[1][62:31], i_num[0][62:31]};
            assign w_low  = {i_num[2][30:0], i_num[1][30:0], i_num[0][30:0]};
            assign w_quot = '0;
            assign w_den  = i_den;
            assign w_ctx  = i_ctx;
        end else begin : g_next
            assign w_vld  = r_vld[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_low  = r_low[k-1];
            assign w_quot = r_quot[k-1];
            assign w_den  = r_den[k-1];
            assign w_ctx  = r_ctx[k-1];
        end

        // one trial subtract per lane
        always_comb begin
            logic [32:0] v_x;
            for (int l = 0; l < 3; l++) begin
                v_x        = {w_rem[l], w_low[l][30]};
                w_take[l]  = (v_x >= {1'b0, w_den});
                w_rem_n[l] = w_take[l] ? 32'(v_x - {1'b0, w_den}) : v_x[31:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < 3; l++) begin
                    r_rem[k][l]  <= w_rem_n[l];
                    r_low[k][l]  <= {w_low[l][29:0], 1'b0};
                    r_quot[k][l] <= {w_quot[l][29:0], w_take[l]};
                end
                r_den[k] <= w_den;
                r_ctx[k] <= w_ctx;
            end
        end
    end

    assign o_valid = r_vld[DIV_STAGES-1];
    assign o_quot  = r_quot[DIV_STAGES-1];
    assign o_ctx   = r_ctx[DIV_STAGES-1];

endmodule

// ===== design/close_pair_separator_core.sv =====
// Close pair separator: pushes an atom pair apart to the expanded minimum distance.
// Stages from input transfer to o_out_valid: 4 front stages, 32 square
//   root stages, 1 dividend stage, 31 divider stages, 2 scaling stages, output register.
// Throughput: one pair per cycle unless halted; the square root and divider retire one bit per stage.
// The pipeline halts only when its last stage and the output register are both full
//   and the held result is not taken.
// Reset (i_rst_n low, synchronous) clears all valid bits and the configuration registers.
`timescale 1ns / 1ps

module close_pair_separator_core import cps_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [31:0]        i_pos_ix,
    input  logic [31:0]        i_pos_iy,
    input  logic [31:0]        i_pos_iz,
    input  logic [31:0]        i_pos_jx,
    input  logic [31:0]        i_pos_jy,
    input  logic [31:0]        i_pos_jz,
    input  logic               i_species_i,
    input  logic               i_species_j,
    input  logic               i_j_is_local,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_new_ix,
    output logic [31:0]        o_new_iy,
    output logic [31:0]        o_new_iz,
    output logic [31:0]        o_new_jx,
    output logic [31:0]        o_new_jy,
    output logic [31:0]        o_new_jz,
    output logic               o_moved,
    output logic               o_coincident
);

    // saturate a 37-bit signed value to 32 bits
    function automatic logic [31:0] sat32(input logic [36:0] v);
        logic [31:0] res;
        if (v[36:31] == 6'b000000 || v[36:31] == 6'b111111) begin
            res = v[31:0];
        end else if (v[36]) begin
            res = 32'h8000_0000;
        end else begin
            res = 32'h7FFF_FFFF;
        end
        return res;
    endfunction

    localparam logic [49:0] RND_T = 50'd1 << 15;
    localparam logic [64:0] RND_G = 65'd1 << 29;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [31:0] r_min_same_a;
    logic [31:0] r_min_mixed;
    logic [31:0] r_min_same_b;
    logic [15:0] r_expand;
    logic [1:0]  w_reg_idx;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_same_a <= '0;
            r_min_mixed  <= '0;
            r_min_same_b <= '0;
            r_expand     <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_reg_idx)
                REG_MIN_SAME_A: r_min_same_a <= pwdata;
                REG_MIN_MIXED:  r_min_mixed  <= pwdata;
                REG_MIN_SAME_B: r_min_same_b <= pwdata;
                REG_EXPAND:     r_expand     <= pwdata[15:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_MIN_SAME_A: prdata = r_min_same_a;
            REG_MIN_MIXED:  prdata = r_min_mixed;
            REG_MIN_SAME_B: prdata = r_min_same_b;
            REG_EXPAND:     prdata = {16'b0, r_expand};
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Flow control: everything moves unless the last stage would overrun
    // a waiting result
    // ---------------------------------------------------------------
    logic r_out_vld;
    logic r_g_vld;
    logic w_adv;

    assign w_adv      = !(r_g_vld && r_out_vld && !i_out_ready);
    assign o_in_ready = w_adv;

    // ---------------------------------------------------------------
    // Stage A: differences, magnitudes, minimum distance lookup
    // ---------------------------------------------------------------
    t_ctx        w_a_ctx;
    logic [31:0] w_a_d;
    logic        w_si;
    logic        w_sj;

    always_comb begin
        logic [32:0] v_del;
        w_a_ctx          = '0;
        w_a_ctx.pi       = {i_pos_iz, i_pos_iy, i_pos_ix};
        w_a_ctx.pj       = {i_pos_jz, i_pos_jy, i_pos_jx};
        w_a_ctx.is_local = i_j_is_local;
        for (int l = 0; l < 3; l++) begin
            v_del = {w_a_ctx.pi[l][31], w_a_ctx.pi[l]} - {w_a_ctx.pj[l][31], w_a_ctx.pj[l]};
            w_a_ctx.neg[l] = v_del[32];
            w_a_ctx.mag[l] = v_del[32] ? 32'(33'd0 - v_del) : v_del[31:0];
        end
    end

    // fold species onto the available types
    assign w_si = (NUM_TYPES > 1) ? i_species_i : 1'b0;
    assign w_sj = (NUM_TYPES > 1) ? i_species_j : 1'b0;

    always_comb begin
        if (w_si != w_sj) begin
            w_a_d = r_min_mixed;
        end else if (!w_si) begin
            w_a_d = r_min_same_a;
        end else begin
            w_a_d = r_min_same_b;
        end
    end

    logic        r_a_vld;
    t_ctx        r_a_ctx;
    logic [31:0] r_a_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_adv) begin
            r_a_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_ctx <= w_a_ctx;
            r_a_d   <= w_a_d;
        end
    end

    // ---------------------------------------------------------------
    // Stage B: squares, squared minimum, unrounded target
    // ---------------------------------------------------------------
    logic             r_b_vld;
    t_ctx             r_b_ctx;
    logic [2:0][63:0] r_b_sq;
    logic [63:0]      r_b_dsq;
    logic [48:0]      r_b_tprod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_adv) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int l = 0; l < 3; l++) begin
                r_b_sq[l] <= {32'b0, r_a_ctx.mag[l]} * {32'b0, r_a_ctx.mag[l]};
            end
            r_b_dsq   <= {32'b0, r_a_d} * {32'b0, r_a_d};
            r_b_tprod <= {17'b0, r_a_d} * {32'b0, 1'b1, r_expand};
            r_b_ctx   <= r_a_ctx;
        end
    end

    // ---------------------------------------------------------------
    // Stage C: squared separation, rounded target
    // ---------------------------------------------------------------
    logic        r_c_vld;
    t_ctx        r_c_ctx;
    t_ctx        w_c_ctx;
    logic [65:0] r_c_rsq;
    logic [63:0] r_c_dsq;
    logic [49:0] w_c_trnd;

    assign w_c_trnd = {1'b0, r_b_tprod} + RND_T;

    always_comb begin
        w_c_ctx     = r_b_ctx;
        w_c_ctx.tgt = w_c_trnd[48:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_adv) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_rsq <= {2'b0, r_b_sq[0]} + {2'b0, r_b_sq[1]} + {2'b0, r_b_sq[2]};
            r_c_dsq <= r_b_dsq;
            r_c_ctx <= w_c_ctx;
        end
    end

    // ---------------------------------------------------------------
    // Stage D: classify the pair
    // ---------------------------------------------------------------
    logic        r_d_vld;
    t_ctx        r_d_ctx;
    t_ctx        w_d_ctx;
    logic [63:0] r_d_rsq;

    always_comb begin
        w_d_ctx       = r_c_ctx;
        w_d_ctx.coinc = (r_c_rsq == '0);
        w_d_ctx.near  = (r_c_rsq[65:64] == 2'b00) && (r_c_rsq != '0)
                        && (r_c_rsq[63:0] <= r_c_dsq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (w_adv) begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d_rsq <= r_c_rsq[63:0];
            r_d_ctx <= w_d_ctx;
        end
    end

    // ---------------------------------------------------------------
    // Square root of the squared separation
    // ---------------------------------------------------------------
    logic        w_s_vld;
    logic [31:0] w_s_root;
    t_ctx        w_s_ctx;

    cps_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_d_vld),
        .i_rad   (r_d_rsq),
        .i_ctx   (r_d_ctx),
        .o_valid (w_s_vld),
        .o_root  (w_s_root),
        .o_ctx   (w_s_ctx)
    );

    // ---------------------------------------------------------------
    // Stage E: dividends |del|*2^30 + r/2
    // ---------------------------------------------------------------
    logic             r_e_vld;
    t_ctx             r_e_ctx;
    logic [2:0][62:0] r_e_num;
    logic [31:0]      r_e_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (w_adv) begin
            r_e_vld <= w_s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int l = 0; l < 3; l++) begin
                r_e_num[l] <= {1'b0, w_s_ctx.mag[l], 30'b0} + {32'b0, w_s_root[31:1]};
            end
            r_e_den <= w_s_root;
            r_e_ctx <= w_s_ctx;
        end
    end

    // ---------------------------------------------------------------
    // Unit direction components, Q1.30
    // ---------------------------------------------------------------
    logic             w_q_vld;
    logic [2:0][30:0] w_q_quot;
    t_ctx             w_q_ctx;

    cps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_e_vld),
        .i_num   (r_e_num),
        .i_den   (r_e_den),
        .i_ctx   (r_e_ctx),
        .o_valid (w_q_vld),
        .o_quot  (w_q_quot),
        .o_ctx   (w_q_ctx)
    );

    // ---------------------------------------------------------------
    // Stage F: scale by target separation
    // ---------------------------------------------------------------
    logic             r_f_vld;
    t_ctx             r_f_ctx;
    logic [2:0][63:0] r_f_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (w_adv) begin
            r_f_vld <= w_q_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int l = 0; l < 3; l++) begin
                r_f_prod[l] <= {33'b0, w_q_quot[l]} * {31'b0, w_q_ctx.tgt};
            end
            r_f_ctx <= w_q_ctx;
        end
    end

    // ---------------------------------------------------------------
    // Stage G: round to Q16.16 and restore the sign
    // ---------------------------------------------------------------
    t_ctx             r_g_ctx;
    logic [2:0][35:0] r_g_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else if (w_adv) begin
            r_g_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [64:0] v_rnd;
        logic [35:0] v_gm;
        if (w_adv) begin
            for (int l = 0; l < 3; l++) begin
                v_rnd = {1'b0, r_f_prod[l]} + RND_G;
                v_gm  = {1'b0, v_rnd[64:30]};
                r_g_off[l] <= r_f_ctx.neg[l] ? 36'(36'd0 - v_gm) : v_gm;
            end
            r_g_ctx <= r_f_ctx;
        end
    end

    // ---------------------------------------------------------------
    // Output register: midpoint +/- offset, halved and saturated
    // ---------------------------------------------------------------
    logic [2:0][31:0] w_h_ni;
    logic [2:0][31:0] w_h_nj;

    always_comb begin
        logic [36:0] v_s;
        logic [36:0] v_g;
        logic [36:0] v_a;
        logic [36:0] v_b;
        for (int l = 0; l < 3; l++) begin
            v_s = {{5{r_g_ctx.pi[l][31]}}, r_g_ctx.pi[l]}
                + {{5{r_g_ctx.pj[l][31]}}, r_g_ctx.pj[l]};
            v_g = {r_g_off[l][35], r_g_off[l]};
            v_a = v_s + v_g;
            v_b = v_s - v_g;
            w_h_ni[l] = r_g_ctx.near ? sat32({v_a[36], v_a[36:1]}) : r_g_ctx.pi[l];
            w_h_nj[l] = (r_g_ctx.near && r_g_ctx.is_local)
                      ? sat32({v_b[36], v_b[36:1]}) : r_g_ctx.pj[l];
        end
    end

    logic [2:0][31:0] r_out_ni;
    logic [2:0][31:0] r_out_nj;
    logic             r_out_moved;
    logic             r_out_coinc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!r_out_vld || i_out_ready) begin
            r_out_vld <= r_g_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_out_ready) begin
            r_out_ni    <= w_h_ni;
            r_out_nj    <= w_h_nj;
            r_out_moved <= r_g_ctx.near;
            r_out_coinc <= r_g_ctx.coinc;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_new_ix     = r_out_ni[0];
    assign o_new_iy     = r_out_ni[1];
    assign o_new_iz     = r_out_ni[2];
    assign o_new_jx     = r_out_nj[0];
    assign o_new_jy     = r_out_nj[1];
    assign o_new_jz     = r_out_nj[2];
    assign o_moved      = r_out_moved;
    assign o_coincident = r_out_coinc;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // input side stalls only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without a held result");

    // a separated pair never also reports zero distance
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_moved && o_coincident))
        else $error("moved and coincident both set");

    // unit components of a close pair never exceed one
    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_vld && w_q_ctx.near) |->
            (w_q_quot[0] <= 31'h4000_0000 && w_q_quot[1] <= 31'h4000_0000
             && w_q_quot[2] <= 31'h4000_0000))
        else $error("direction component out of range");

    // a held result stays put while the pipeline is halted
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready && !w_adv) |=> (o_out_valid && $stable(r_out_ni)))
        else $error("held result changed during stall");

endmodule
